// ===== rtl/integer_to_roman_numeral_assert.svh =====
// Assertion macros shared by the integer to Roman numeral modules.
`ifndef INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2r_pkg.sv =====
// Shared types, constants and character tables for the Roman numeral converter.
package i2r_pkg;

  localparam int NUM_W      = 12;
  localparam int IN_TDATA_W = 16;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_PLACES = 4;
  localparam int PLACE_W    = 2;
  localparam int POS_W      = 2;
  localparam int LEN_W      = 3;
  localparam int TH_W       = 2;
  localparam int REM1_W     = 10;
  localparam int REM2_W     = 7;

  localparam logic [NUM_W-1:0] MAX_VALUE = NUM_W'(3999);
  localparam int THOUSAND = 1000;
  localparam int HUNDRED  = 100;
  localparam int TEN      = 10;

  // Place indexes, most significant first
  localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_HUNDREDS  = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_TENS      = 2'd2;
  localparam logic [PLACE_W-1:0] PLACE_ONES      = 2'd3;

  localparam logic [POS_W-1:0] NA_LAST_POS = 2'd2;

  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
  localparam logic [CHAR_W-1:0] CH_V     = 8'h56;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_t;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Decimal digits of one number, thousands first, plus the N/A flag
  typedef struct packed {
    logic                        na;
    digit_t [NUM_PLACES-1:0]     digit;
  } digit_item_t;

  // Number of characters a decimal digit spells in one place
  function automatic logic [LEN_W-1:0] digit_len(input digit_t d);
    logic [LEN_W-1:0] len;
    case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Symbol at position pos of a digit's spelling
  function automatic sym_t digit_sym(input digit_t d, input logic [POS_W-1:0] pos);
    sym_t s;
    case (d)
      4'd4:    s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd5, 4'd6, 4'd7, 4'd8:
               s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
      4'd9:    s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
      default: s = SYM_ONE;
    endcase
    return s;
  endfunction

  // Letter of a symbol in a given place
  function automatic logic [CHAR_W-1:0] place_char(input logic [PLACE_W-1:0] place,
                                                   input sym_t s);
    logic [CHAR_W-1:0] c;
    case (place)
      PLACE_THOUSANDS: c = CH_M;
      PLACE_HUNDREDS: begin
        case (s)
          SYM_ONE:  c = CH_C;
          SYM_FIVE: c = CH_D;
          SYM_TEN:  c = CH_M;
          default:  c = CH_C;
        endcase
      end
      PLACE_TENS: begin
        case (s)
          SYM_ONE:  c = CH_X;
          SYM_FIVE: c = CH_L;
          SYM_TEN:  c = CH_C;
          default:  c = CH_X;
        endcase
      end
      default: begin
        case (s)
          SYM_ONE:  c = CH_I;
          SYM_FIVE: c = CH_V;
          SYM_TEN:  c = CH_X;
          default:  c = CH_I;
        endcase
      end
    endcase
    return c;
  endfunction

  // Letters of the not-available answer
  function automatic logic [CHAR_W-1:0] na_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      2'd0:    c = CH_N;
      2'd1:    c = CH_SLASH;
      default: c = CH_A;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/i2r_digit_split.sv =====
// Three-stage pipeline that splits a binary number into decimal digits.
`include "integer_to_roman_numeral_assert.svh"

module i2r_digit_split (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [i2r_pkg::NUM_W-1:0]    in_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output i2r_pkg::digit_item_t         out_item
);
  import i2r_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3;
  logic                na1_r, na2_r;
  logic [TH_W-1:0]     th1_r, th2_r;
  logic [REM1_W-1:0]   rem1_r;
  digit_t              hu2_r;
  logic [REM2_W-1:0]   rem2_r;
  digit_item_t         item3_r;

  logic                na1_nxt;
  logic [TH_W-1:0]     th1_nxt;
  logic [REM1_W-1:0]   rem1_nxt;
  digit_t              hu2_nxt;
  logic [REM2_W-1:0]   rem2_nxt;
  digit_t              te3_nxt;
  digit_t              on3_nxt;
  logic [NUM_W-1:0]    sub1;
  logic [REM1_W-1:0]   sub2;
  logic [REM2_W-1:0]   sub3;

  // A stage takes new data when empty or when its contents move on
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: flag out-of-range values, peel off thousands
  always_comb begin
    na1_nxt = (in_number == '0) || (in_number > MAX_VALUE);
    th1_nxt = '0;
    sub1    = '0;
    for (int k = 1; k <= 3; k++) begin
      if (in_number >= NUM_W'(k * THOUSAND)) begin
        th1_nxt = TH_W'(k);
        sub1    = NUM_W'(k * THOUSAND);
      end
    end
    rem1_nxt = REM1_W'(in_number - sub1);
  end

  // Stage 2: peel off hundreds
  always_comb begin
    hu2_nxt = '0;
    sub2    = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem1_r >= REM1_W'(k * HUNDRED)) begin
        hu2_nxt = DIGIT_W'(k);
        sub2    = REM1_W'(k * HUNDRED);
      end
    end
    rem2_nxt = REM2_W'(rem1_r - sub2);
  end

  // Stage 3: split the rest into tens and ones
  always_comb begin
    te3_nxt = '0;
    sub3    = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem2_r >= REM2_W'(k * TEN)) begin
        te3_nxt = DIGIT_W'(k);
        sub3    = REM2_W'(k * TEN);
      end
    end
    on3_nxt = DIGIT_W'(rem2_r - sub3);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Advance payload, hold on stall
  always_ff @(posedge clk) begin
    if (rdy1) begin
      na1_r  <= na1_nxt;
      th1_r  <= th1_nxt;
      rem1_r <= rem1_nxt;
    end
    if (rdy2) begin
      na2_r  <= na1_r;
      th2_r  <= th1_r;
      hu2_r  <= hu2_nxt;
      rem2_r <= rem2_nxt;
    end
    if (rdy3) begin
      item3_r.na                     <= na2_r;
      item3_r.digit[PLACE_THOUSANDS] <= DIGIT_W'(th2_r);
      item3_r.digit[PLACE_HUNDREDS]  <= hu2_r;
      item3_r.digit[PLACE_TENS]      <= te3_nxt;
      item3_r.digit[PLACE_ONES]      <= on3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item3_r;

  `I2R_ASSERT_NOW(a_rem2_range, v2_r && !na2_r, rem2_r < REM2_W'(HUNDRED), "remainder after hundreds out of range")
  `I2R_ASSERT_NOW(a_digits_decimal, v3_r && !item3_r.na, (item3_r.digit[PLACE_HUNDREDS] <= 4'd9) && (item3_r.digit[PLACE_TENS] <= 4'd9) && (item3_r.digit[PLACE_ONES] <= 4'd9), "digit above nine")
  `I2R_ASSERT_NEXT(a_tail_held, v3_r && !out_ready, v3_r && $stable(item3_r), "stalled digit item lost")

endmodule

// ===== rtl/i2r_serializer.sv =====
// Walks the decimal digits of one item and sends its numeral one character at a time.
`include "integer_to_roman_numeral_assert.svh"

module i2r_serializer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  i2r_pkg::digit_item_t          in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2r_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);
  import i2r_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 na_r, na_nxt;
  digit_t [NUM_PLACES-1:0] dig_r, dig_nxt;
  logic [PLACE_W-1:0]   place_r, place_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 oval_r, oval_nxt;
  logic [CHAR_W-1:0]    ochar_r, ochar_nxt;
  logic                 olast_r, olast_nxt;

  digit_t               cur_digit;
  logic [LEN_W-1:0]     cur_len;
  logic [CHAR_W-1:0]    cur_char;
  logic                 digit_end;
  logic                 later_found;
  logic [PLACE_W-1:0]   later_place;
  logic [PLACE_W-1:0]   first_place;
  logic                 last_char;
  logic                 emit;
  logic                 load;

  // Current character and where the walk goes next
  always_comb begin
    cur_digit = dig_r[place_r];
    cur_len   = digit_len(cur_digit);
    cur_char  = na_r ? na_char(pos_r) : place_char(place_r, digit_sym(cur_digit, pos_r));
    digit_end = ({1'b0, pos_r} == LEN_W'(cur_len - 3'd1));

    later_found = 1'b0;
    later_place = place_r;
    for (int j = NUM_PLACES - 1; j >= 0; j--) begin
      if ((j > int'(place_r)) && (dig_r[j] != '0)) begin
        later_found = 1'b1;
        later_place = PLACE_W'(j);
      end
    end

    first_place = PLACE_ONES;
    for (int j = NUM_PLACES - 1; j >= 0; j--) begin
      if (in_item.digit[j] != '0) first_place = PLACE_W'(j);
    end

    last_char = na_r ? (pos_r == NA_LAST_POS) : (digit_end && !later_found);
  end

  // Send when the output register is free or being drained
  assign emit     = busy_r && (!oval_r || out_ready);
  assign in_ready = !busy_r || (emit && last_char);
  assign load     = in_valid && in_ready;

  // Walk state
  always_comb begin
    busy_nxt  = busy_r;
    na_nxt    = na_r;
    dig_nxt   = dig_r;
    place_nxt = place_r;
    pos_nxt   = pos_r;
    if (load) begin
      busy_nxt  = 1'b1;
      na_nxt    = in_item.na;
      dig_nxt   = in_item.digit;
      place_nxt = first_place;
      pos_nxt   = '0;
    end else if (emit && last_char) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      if (na_r || !digit_end) begin
        pos_nxt = pos_r + 2'd1;
      end else begin
        place_nxt = later_place;
        pos_nxt   = '0;
      end
    end
  end

  // Output register
  always_comb begin
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      ochar_nxt = cur_char;
      olast_nxt = last_char;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= na_nxt;
    dig_r   <= dig_nxt;
    place_r <= place_nxt;
    pos_r   <= pos_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

  `I2R_ASSERT_NOW(a_na_pos, busy_r && na_r, pos_r <= NA_LAST_POS, "N/A position past its last letter")
  `I2R_ASSERT_NOW(a_load_on_last, load && busy_r, emit && last_char, "new item taken before the numeral ended")
  `I2R_ASSERT_NEXT(a_idle_after_last, emit && last_char && !load, !busy_r && out_last, "walk did not stop on the last character")
  `I2R_ASSERT_NOW(a_digit_nonempty, busy_r && !na_r, cur_len != 3'd0, "walk parked on an empty digit")

endmodule

// ===== rtl/integer_to_roman_numeral.sv =====
// Path: the first character of a number passes the three digit-split stages, then the
//   character walker's walk state and its output register.
// Throughput: one character per cycle while out_tready is high and numbers keep coming; a
//   numeral has 1 to 15 characters, and the single-character output port sets that rate.
// Reset: synchronous active-low rst_n empties the pipeline and the output register.
module integer_to_roman_numeral (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2r_pkg::IN_TDATA_W-1:0]    in_tdata,   // [11:0] number, [15:12] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2r_pkg::CHAR_W-1:0]        out_tdata,  // [7:0] char_code
  output logic                              out_tlast
);
  import i2r_pkg::*;

  logic        split_valid;
  logic        split_ready;
  digit_item_t split_item;

  // Binary to decimal digits
  i2r_digit_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_number (in_tdata[NUM_W-1:0]),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_item  (split_item)
  );

  // Digits to characters
  i2r_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_item   (split_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== tb/tb_integer_to_roman_numeral.sv =====
// Testbench for the integer to Roman numeral converter: predicted character streams vs. output.
module tb_integer_to_roman_numeral;
  timeunit 1ns;
  timeprecision 1ps;

  import i2r_pkg::*;

  localparam int STEPS       = 13;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int DRAIN_WAIT  = 20;

  // Greedy conversion steps, largest first; a zero tail means a single letter
  localparam int STEP_AMT [STEPS] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  localparam logic [CHAR_W-1:0] STEP_LEAD [STEPS] =
    '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
  localparam logic [CHAR_W-1:0] STEP_TAIL [STEPS] =
    '{8'h00, CH_M, 8'h00, CH_D, 8'h00, CH_C, 8'h00, CH_L, 8'h00, CH_X, 8'h00, CH_V, 8'h00};

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } roman_char_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // [11:0] number, [15:12] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CHAR_W-1:0]     out_tdata;  // [7:0] char_code
  logic                  out_tlast;

  roman_char_t pending_chars[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          ready_stall = 0;
  bit          no_gaps = 1'b0;

  integer_to_roman_numeral dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Zero half the time, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Spell one number and queue its characters, flag on the final one
  function automatic void spell_roman(input logic [NUM_W-1:0] num);
    roman_char_t word[$];
    roman_char_t ch;
    int          rest;
    rest = num;
    ch.last = 1'b0;
    if (rest == 0 || rest > MAX_VALUE) begin
      ch.code = CH_N;     word.push_back(ch);
      ch.code = CH_SLASH; word.push_back(ch);
      ch.code = CH_A;     word.push_back(ch);
    end else begin
      for (int i = 0; i < STEPS; i++) begin
        while (rest >= STEP_AMT[i]) begin
          ch.code = STEP_LEAD[i];
          word.push_back(ch);
          if (STEP_TAIL[i] != 8'h00) begin
            ch.code = STEP_TAIL[i];
            word.push_back(ch);
          end
          rest -= STEP_AMT[i];
        end
      end
    end
    word[word.size() - 1].last = 1'b1;
    foreach (word[k]) pending_chars.push_back(word[k]);
  endfunction

  // Offer one number after an optional gap; return at the edge of its transfer
  task automatic send_number(input logic [NUM_W-1:0] num);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - NUM_W){1'b0}}, num};
    do @(posedge clk); while (!in_tready);
    spell_roman(num);
  endtask

  // Boundaries, every subtractive pair, the longest numeral and the N/A range
  task automatic test_directed();
    int picks[$];
    picks = '{1, 3999, 3888, 4, 9, 40, 90, 400, 900, 5, 50, 500, 1000, 1994, 444, 999, 14,
              2048, 0, 4000, 4095, 3000, 8};
    foreach (picks[k]) send_number(NUM_W'(picks[k]));
  endtask

  // Back-to-back transfers with no new sink stalls started
  task automatic test_full_rate();
    no_gaps = 1'b1;
    repeat (40) send_number(NUM_W'($urandom_range(1, 3999)));
    send_number(NUM_W'(3888));
    send_number(NUM_W'(0));
    send_number(NUM_W'(3888));
    no_gaps = 1'b0;
  endtask

  // Random numbers with gaps and stalls, weighted toward valid numerals
  task automatic test_random_numbers();
    int r;
    repeat (260) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send_number(NUM_W'($urandom_range(1, 3999)));
      else if (r < 90)
        send_number(($urandom_range(0, 3) == 0) ? NUM_W'(0) : NUM_W'($urandom_range(4000, 4095)));
      else
        send_number(NUM_W'($urandom_range(0, 4095)));
    end
  endtask

  // Sink stalls: random lengths, no new ones started while a full-rate phase runs
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      out_tready  <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_tready  <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) ready_stall <= pick_gap();
    end
  end

  // Compare each output transfer with the oldest expected character
  always @(posedge clk) begin
    roman_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual code %h last %b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.code) begin
          $display("%0t: char_code mismatch: expected %h, actual %h",
                   $time, want.code, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: is_last mismatch: expected %b, actual %b",
                   $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_integer_to_roman_numeral NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_rate();
    test_random_numbers();
    in_tvalid <= 1'b0;

    // Drain, then allow stray transfers to show up
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0)
      $display("tb_integer_to_roman_numeral OK");
    else
      $display("tb_integer_to_roman_numeral NOT OK");
    $finish;
  end

endmodule
